FILE: rtl/npli_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// npli_pkg: shared types and codes of the table interpolator
// Beat payloads, operation and status codes, and the command and status
// bundles that pass between the controller and the datapath.
// ============================================================================
package npli_pkg;

    localparam logic       OP_WRITE     = 1'b0;
    localparam logic       OP_QUERY     = 1'b1;

    localparam logic [1:0] STATUS_WRITE = 2'd0;
    localparam logic [1:0] STATUS_OK    = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    localparam logic [8:0] POINT_COUNT_RESET = 9'd2;

    typedef struct packed {
        logic               operation;
        logic [7:0]         entry_index;
        logic signed [31:0] x_value;
        logic signed [31:0] y_real;
        logic signed [31:0] y_imag;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] result_real;
        logic signed [31:0] result_imag;
        logic [1:0]         status;
    } t_out_item;

    // Table read address source.
    typedef enum logic [2:0] {
        ADDR_ZERO,
        ADDR_LAST,
        ADDR_SCAN,
        ADDR_A,
        ADDR_B
    } t_addr_sel;

    // Segment end point selection.
    typedef enum logic [1:0] {
        AB_HOLD,
        AB_FIRST,
        AB_LAST,
        AB_SCAN
    } t_ab_sel;

    // Result register update.
    typedef enum logic [2:0] {
        RES_HOLD,
        RES_WRITE,
        RES_RANGE,
        RES_DEGEN,
        RES_PART
    } t_res_sel;

    typedef struct packed {
        logic      load_item;
        logic      ram_we;
        t_addr_sel addr_sel;
        logic      cap_first;
        logic      idx_clear;
        logic      scan_issue;
        t_ab_sel   ab_sel;
        logic      cap_a;
        logic      cap_b;
        logic      mul_start;
        logic      div_step;
        logic      part_clear;
        logic      part_next;
        t_res_sel  res_sel;
        logic      out_load;
    } t_cmd;

    typedef struct packed {
        logic in_query;
        logic out_range;
        logic at_first;
        logic at_last;
        logic scan_last;
        logic dx_zero;
        logic div_done;
        logic part_imag;
    } t_stat;

endpackage
`default_nettype wire

FILE: rtl/npli_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// npli_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
module npli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/npli_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// npli_datapath: table storage, nearest-point scan and segment arithmetic
// Holds the breakpoint and value RAMs, the scan comparator, one shared
// 32x32 multiplier and a radix-2 restoring divider for the slope term.
// ============================================================================
module npli_datapath import npli_pkg::*; #(
    parameter int MAX_POINTS = 256
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_cfg_we,
    input  wire logic [8:0] i_cfg_data,
    input  wire t_in_item  i_data,
    input  wire t_cmd      i_cmd,
    output t_stat          o_stat,
    output t_out_item      o_data
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = (AW + 1 > 9) ? AW + 1 : 9;
    localparam logic [63:0] Q_LIMIT = 64'h0000_0002_0000_0000;

    function automatic logic [31:0] mag33(input logic [32:0] v);
        logic [32:0] neg_v;
        neg_v = -v;
        return v[32] ? neg_v[31:0] : v[31:0];
    endfunction

    // Configuration and captured item.
    logic [8:0]          r_point_count;
    t_in_item            r_item;

    // Scan state.
    logic [AW-1:0]       r_idx;
    logic                r_cmp_v;
    logic [AW-1:0]       r_cmp_idx;
    logic [32:0]         r_best_d;
    logic [AW-1:0]       r_ns;
    logic signed [31:0]  r_best_x;
    logic signed [31:0]  r_x_first;

    // Segment state.
    logic [AW-1:0]       r_a;
    logic [AW-1:0]       r_b;
    logic signed [31:0]  r_x0;
    logic signed [31:0]  r_y0_re;
    logic signed [31:0]  r_y0_im;
    logic signed [32:0]  r_dx;
    logic signed [32:0]  r_dxq;
    logic signed [32:0]  r_dy_re;
    logic signed [32:0]  r_dy_im;
    logic                r_part;

    // Divider state.
    logic [63:0]         r_quo;
    logic [31:0]         r_rem;
    logic [31:0]         r_div;
    logic [5:0]          r_cnt;
    logic                r_neg;

    // Result and output beat.
    logic signed [31:0]  r_res_re;
    logic signed [31:0]  r_res_im;
    logic [1:0]          r_res_st;
    t_out_item           r_out;

    logic [CW-1:0]       cnt_w;
    logic [AW-1:0]       last_idx;
    logic [AW-1:0]       raddr;
    logic                idx_ok;
    logic [31:0]         x_rdata;
    logic [63:0]         v_rdata;
    logic signed [32:0]  scan_diff;
    logic [32:0]         scan_abs;
    logic                ab_guard;
    logic [AW-1:0]       ab_scan_a;
    logic [AW-1:0]       ab_scan_b;
    logic signed [32:0]  dy_sel;
    logic [63:0]         product;
    logic [32:0]         rem_sh;
    logic                q_bit;
    logic signed [31:0]  y0_sel;
    logic signed [34:0]  y0_ext;
    logic signed [34:0]  q_ext;
    logic signed [34:0]  sum;
    logic signed [31:0]  fix;

    // Clamp the count register to at least two points and at most the table size.
    always_comb begin
        cnt_w = CW'(r_point_count);
        if (cnt_w < CW'(2)) begin
            last_idx = AW'(1);
        end else if (cnt_w > CW'(MAX_POINTS)) begin
            last_idx = AW'(MAX_POINTS - 1);
        end else begin
            last_idx = AW'(cnt_w - CW'(1));
        end
    end

    assign idx_ok = (32'(r_item.entry_index) < 32'(MAX_POINTS));

    always_comb begin
        case (i_cmd.addr_sel)
            ADDR_ZERO: raddr = '0;
            ADDR_LAST: raddr = last_idx;
            ADDR_SCAN: raddr = r_idx;
            ADDR_A:    raddr = r_a;
            ADDR_B:    raddr = r_b;
            default:   raddr = '0;
        endcase
    end

    npli_ram #(
        .WIDTH (32),
        .DEPTH (MAX_POINTS)
    ) u_x_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ram_we && idx_ok),
        .i_waddr (AW'(r_item.entry_index)),
        .i_wdata (r_item.x_value),
        .i_raddr (raddr),
        .o_rdata (x_rdata)
    );

    npli_ram #(
        .WIDTH (64),
        .DEPTH (MAX_POINTS)
    ) u_v_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ram_we && idx_ok),
        .i_waddr (AW'(r_item.entry_index)),
        .i_wdata ({r_item.y_real, r_item.y_imag}),
        .i_raddr (raddr),
        .o_rdata (v_rdata)
    );

    // Distance from the query to the breakpoint read back this cycle.
    always_comb begin
        scan_diff = {r_item.x_value[31], r_item.x_value} - {x_rdata[31], x_rdata};
        scan_abs  = scan_diff[32] ? -scan_diff : scan_diff;
    end

    // Use the segment right of the nearest point if the query lies right of it, else the one left of it.
    always_comb begin
        ab_guard  = 1'b0;
        ab_scan_a = r_ns;
        ab_scan_b = r_ns;
        if (r_item.x_value > r_best_x) begin
            if (r_ns == last_idx) begin
                ab_guard = 1'b1;
            end else begin
                ab_scan_b = r_ns + AW'(1);
            end
        end else begin
            if (r_ns == '0) begin
                ab_guard = 1'b1;
            end else begin
                ab_scan_a = r_ns - AW'(1);
            end
        end
    end

    assign dy_sel  = r_part ? r_dy_im : r_dy_re;
    assign product = mag33(dy_sel) * mag33(r_dxq);

    always_comb begin
        rem_sh = {r_rem, r_quo[63]};
        q_bit  = (rem_sh >= {1'b0, r_div});
    end

    // Final add of the slope term with saturation to 32 bits.
    always_comb begin
        y0_sel = r_part ? r_y0_im : r_y0_re;
        y0_ext = {{3{y0_sel[31]}}, y0_sel};
        q_ext  = {1'b0, r_quo[33:0]};
        sum    = r_neg ? (y0_ext - q_ext) : (y0_ext + q_ext);
        if (r_quo > Q_LIMIT) begin
            fix = r_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else if (!sum[34] && (sum[33:31] != 3'b000)) begin
            fix = 32'sh7FFF_FFFF;
        end else if (sum[34] && (sum[33:31] != 3'b111)) begin
            fix = 32'sh8000_0000;
        end else begin
            fix = sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= POINT_COUNT_RESET;
            r_cmp_v       <= 1'b0;
            r_idx         <= '0;
            r_part        <= 1'b0;
            r_cnt         <= '0;
        end else begin
            if (i_cfg_we) begin
                r_point_count <= i_cfg_data;
            end
            r_cmp_v <= i_cmd.scan_issue;
            if (i_cmd.idx_clear) begin
                r_idx <= '0;
            end else if (i_cmd.scan_issue) begin
                r_idx <= r_idx + AW'(1);
            end
            if (i_cmd.part_clear) begin
                r_part <= 1'b0;
            end else if (i_cmd.part_next) begin
                r_part <= 1'b1;
            end
            if (i_cmd.mul_start) begin
                r_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_cnt <= r_cnt + 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_data;
        end
        if (i_cmd.cap_first) begin
            r_x_first <= x_rdata;
        end
        if (i_cmd.scan_issue) begin
            r_cmp_idx <= r_idx;
        end
        // The first compared entry always seeds the minimum; ties keep the earlier one.
        if (r_cmp_v && ((r_cmp_idx == '0) || (scan_abs < r_best_d))) begin
            r_best_d <= scan_abs;
            r_ns     <= r_cmp_idx;
            r_best_x <= x_rdata;
        end
        case (i_cmd.ab_sel)
            AB_FIRST: begin
                r_a <= '0;
                r_b <= '0;
            end
            AB_LAST: begin
                r_a <= last_idx;
                r_b <= last_idx;
            end
            AB_SCAN: begin
                r_a <= ab_guard ? AW'(0) : ab_scan_a;
                r_b <= ab_guard ? AW'(1) : ab_scan_b;
            end
            default: begin
            end
        endcase
        if (i_cmd.cap_a) begin
            r_x0    <= x_rdata;
            r_y0_re <= v_rdata[63:32];
            r_y0_im <= v_rdata[31:0];
            r_dxq   <= {r_item.x_value[31], r_item.x_value} - {x_rdata[31], x_rdata};
        end
        if (i_cmd.cap_b) begin
            r_dx    <= {x_rdata[31], x_rdata} - {r_x0[31], r_x0};
            r_dy_re <= {v_rdata[63], v_rdata[63:32]} - {r_y0_re[31], r_y0_re};
            r_dy_im <= {v_rdata[31], v_rdata[31:0]} - {r_y0_im[31], r_y0_im};
        end
        if (i_cmd.mul_start) begin
            r_quo <= product;
            r_rem <= '0;
            r_div <= mag33(r_dx);
            r_neg <= dy_sel[32] ^ r_dxq[32] ^ r_dx[32];
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[62:0], q_bit};
            r_rem <= q_bit ? 32'(rem_sh - {1'b0, r_div}) : rem_sh[31:0];
        end
        case (i_cmd.res_sel)
            RES_WRITE: begin
                r_res_re <= '0;
                r_res_im <= '0;
                r_res_st <= STATUS_WRITE;
            end
            RES_RANGE: begin
                r_res_re <= '0;
                r_res_im <= '0;
                r_res_st <= STATUS_RANGE;
            end
            RES_DEGEN: begin
                r_res_re <= r_y0_re;
                r_res_im <= r_y0_im;
                r_res_st <= STATUS_OK;
            end
            RES_PART: begin
                if (r_part) begin
                    r_res_im <= fix;
                end else begin
                    r_res_re <= fix;
                end
                r_res_st <= STATUS_OK;
            end
            default: begin
            end
        endcase
        if (i_cmd.out_load) begin
            r_out.result_real <= r_res_re;
            r_out.result_imag <= r_res_im;
            r_out.status      <= r_res_st;
        end
    end

    always_comb begin
        o_stat.in_query  = (i_data.operation == OP_QUERY);
        o_stat.out_range = (r_item.x_value < r_x_first) ||
                           (r_item.x_value > $signed(x_rdata));
        o_stat.at_first  = (r_item.x_value == r_x_first);
        o_stat.at_last   = (r_item.x_value == $signed(x_rdata));
        o_stat.scan_last = (r_idx == last_idx);
        o_stat.dx_zero   = (r_dx == '0);
        o_stat.div_done  = (r_cnt == 6'd63);
        o_stat.part_imag = r_part;
    end

    assign o_data = r_out;

endmodule
`default_nettype wire

FILE: rtl/npli_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// npli_ctrl: sequencer of the table interpolator
// Steps each beat through table write, range check, nearest-point scan,
// segment fetch and the two multiply-divide passes, and owns the handshakes.
// ============================================================================
module npli_ctrl import npli_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    output logic       o_valid,
    input  wire logic  i_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [16:0] {
        S_IDLE   = 17'h00001,
        S_WRITE  = 17'h00002,
        S_QFIRST = 17'h00004,
        S_QLAST  = 17'h00008,
        S_QCHECK = 17'h00010,
        S_SCAN   = 17'h00020,
        S_SDRAIN = 17'h00040,
        S_SEL    = 17'h00080,
        S_RDA    = 17'h00100,
        S_RDB    = 17'h00200,
        S_PREP   = 17'h00400,
        S_DEGEN  = 17'h00800,
        S_MUL    = 17'h01000,
        S_DIV    = 17'h02000,
        S_FIX    = 17'h04000,
        S_FINISH = 17'h08000,
        S_HOLD   = 17'h10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_cmd.addr_sel   = ADDR_ZERO;
        o_cmd.ab_sel     = AB_HOLD;
        o_cmd.res_sel    = RES_HOLD;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state = i_stat.in_query ? S_QFIRST : S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.ram_we  = 1'b1;
                o_cmd.res_sel = RES_WRITE;
                n_state       = S_FINISH;
            end
            S_QFIRST: begin
                o_cmd.addr_sel = ADDR_ZERO;
                n_state        = S_QLAST;
            end
            S_QLAST: begin
                o_cmd.addr_sel  = ADDR_LAST;
                o_cmd.cap_first = 1'b1;
                n_state         = S_QCHECK;
            end
            S_QCHECK: begin
                o_cmd.idx_clear  = 1'b1;
                o_cmd.part_clear = 1'b1;
                if (i_stat.out_range) begin
                    o_cmd.res_sel = RES_RANGE;
                    n_state       = S_FINISH;
                end else if (i_stat.at_first) begin
                    o_cmd.ab_sel = AB_FIRST;
                    n_state      = S_RDA;
                end else if (i_stat.at_last) begin
                    o_cmd.ab_sel = AB_LAST;
                    n_state      = S_RDA;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.addr_sel   = ADDR_SCAN;
                o_cmd.scan_issue = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_SDRAIN;
                end
            end
            S_SDRAIN: begin
                // The last breakpoint is compared in this cycle.
                n_state = S_SEL;
            end
            S_SEL: begin
                o_cmd.ab_sel = AB_SCAN;
                n_state      = S_RDA;
            end
            S_RDA: begin
                o_cmd.addr_sel = ADDR_A;
                n_state        = S_RDB;
            end
            S_RDB: begin
                o_cmd.addr_sel = ADDR_B;
                o_cmd.cap_a    = 1'b1;
                n_state        = S_PREP;
            end
            S_PREP: begin
                o_cmd.cap_b = 1'b1;
                n_state     = S_DEGEN;
            end
            S_DEGEN: begin
                // Equal end points, which also covers a query on a table end.
                if (i_stat.dx_zero) begin
                    o_cmd.res_sel = RES_DEGEN;
                    n_state       = S_FINISH;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_done) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                o_cmd.res_sel = RES_PART;
                if (i_stat.part_imag) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.part_next = 1'b1;
                    n_state         = S_MUL;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

endmodule
`default_nettype wire

FILE: rtl/nearest_point_linear_interpolator.sv
// A table write writes the breakpoint and value RAMs and then gives its beat; a query
// scans every breakpoint in use and, unless the segment end points are equal, runs the
// two multiply-divide passes; a query that is out of range or lands on a table end skips
// the scan. One item is in work at a time: the next beat is taken in the cycle after the
// result moves to the output register. The scan reads one breakpoint RAM entry per cycle.
// Reset is synchronous, active low; the count returns to 2, table contents are kept.
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// nearest_point_linear_interpolator: complex piecewise-linear table lookup
// Top level joining the sequencer and the datapath.
// ============================================================================
module nearest_point_linear_interpolator import npli_pkg::*; #(
    parameter int MAX_POINTS = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [8:0] i_cfg_data,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire t_in_item   i_data,
    output logic            o_valid,
    input  wire logic       i_ready,
    output t_out_item       o_data
);

    t_cmd  cmd;
    t_stat stat;

    npli_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    npli_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_data     (i_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_data     (o_data)
    );

endmodule
`default_nettype wire
